@@ hdl/aofb_pkg.sv @@
// Package for the AES-128 OFB stream block: constants, S-box, round helpers.
// Used by aofb_ctrl, aofb_dp and the top level.
`timescale 1ns / 1ps
`default_nettype none
package aofb_pkg;

   localparam int BlockBytes = 16;
   localparam int PosWidth   = $clog2(BlockBytes);
   localparam int CsrIdxWidth = 2;

   localparam logic [CsrIdxWidth-1:0] CSR_KEY_HIGH = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_KEY_LOW  = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_IV_HIGH  = 2'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_IV_LOW   = 2'd3;

   localparam logic [3:0] LAST_ROUND = 4'd10;

   // controller -> datapath
   typedef struct packed {
      logic start;      // load state = feedback ^ key, first round key = key
      logic round;      // run one AES round
      logic last_round; // skip MixColumns
      logic finish;     // latch keystream and feedback
      logic out_load;   // load output register with the cipher byte
      logic reload_fb;  // feedback from IV
      logic [PosWidth-1:0] pos;
   } cmd_type;

   function automatic logic [7:0] sbox(input logic [7:0] a);
      logic [7:0] t [256];
      t = '{
 8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
 8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
 8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
 8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
 8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
 8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
 8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
 8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
 8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
 8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
 8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
 8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
 8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
 8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
 8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
 8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
      return t[a];
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] b);
      return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
   endfunction

   // byte i of a 128-bit block, byte 0 in the top bits
   function automatic logic [7:0] byte_at(input logic [127:0] w, input int i);
      return w[127-8*i -: 8];
   endfunction

endpackage
`default_nettype wire

@@ hdl/aofb_ctrl.sv @@
// Controller for the AES-128 OFB block: handshakes, byte position, round sequencing.
// Depends on aofb_pkg; drives aofb_dp through cmd_type.
`timescale 1ns / 1ps
`default_nettype none
module aofb_ctrl
   import aofb_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic      req_tready,
   input  wire logic req_tlast,
   output logic      rsp_tvalid,
   input  wire logic rsp_tready,
   input  wire logic iv_write,
   output cmd_type   cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0] state_ff, state_in;
   logic [3:0] round_ff, round_in;
   logic [PosWidth-1:0] pos_ff, pos_in;
   logic out_valid_ff, out_valid_in;
   logic last_ff, last_in;

   logic take, out_free;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign take       = req_tvalid && req_tready;
   assign rsp_tvalid = out_valid_ff;

   always_comb begin
      state_in     = state_ff;
      round_in     = round_ff;
      pos_in       = pos_ff;
      out_valid_in = out_valid_ff;
      last_in      = last_ff;
      cmd          = '0;
      cmd.pos      = pos_ff;
      if (out_valid_ff && rsp_tready) begin
         out_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               last_in = req_tlast;
               if (pos_ff == '0) begin
                  cmd.start = 1'b1;
                  round_in  = 4'd1;
                  state_in  = ST_RUN;
               end else begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_RUN: begin
            cmd.round      = 1'b1;
            cmd.last_round = (round_ff == LAST_ROUND);
            round_in       = round_ff + 4'd1;
            if (round_ff == LAST_ROUND) begin
               cmd.finish = 1'b1;
               state_in   = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // output register is free: nothing accepted while one is pending
            cmd.out_load = 1'b1;
            out_valid_in = 1'b1;
            state_in     = ST_IDLE;
            if (last_ff) begin
               cmd.reload_fb = 1'b1;
               pos_in        = '0;
            end else begin
               pos_in = pos_ff + 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (iv_write) begin
         pos_in        = '0;
         cmd.reload_fb = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         round_ff     <= '0;
         pos_ff       <= '0;
         out_valid_ff <= 1'b0;
         last_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         round_ff     <= round_in;
         pos_ff       <= pos_in;
         out_valid_ff <= out_valid_in;
         last_ff      <= last_in;
      end
   end

   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      take |-> (state_ff == ST_IDLE))
      else $error("beat taken while busy");

   a_round_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (round_ff != 4'd0 && round_ff <= LAST_ROUND))
      else $error("round counter out of range");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!out_valid_ff || rsp_tready))
      else $error("output register overwritten");

endmodule
`default_nettype wire

@@ hdl/aofb_dp.sv @@
// Datapath for the AES-128 OFB block: key and IV registers, round unit with
// on-the-fly key expansion, feedback/keystream and the output register. Uses aofb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module aofb_dp
   import aofb_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_write,
   input  wire logic [CsrIdxWidth-1:0] csr_index,
   input  wire logic [63:0]            csr_data,
   input  wire cmd_type                cmd,
   input  wire logic [7:0]             plain_byte,
   input  wire logic                   end_of_message,
   output logic [7:0]                  cipher_byte,
   output logic                        final_byte
);

   logic [127:0] key_ff, iv_ff, fb_ff, ks_ff, st_ff, rk_ff;
   logic [127:0] key_in, iv_in, fb_in, ks_in, st_in, rk_in;
   logic [7:0]   rcon_ff, rcon_in;
   logic [7:0]   plain_ff, cipher_ff, cipher_in;
   logic         eom_ff, final_ff;
   logic [127:0] sr, mc, nrk, iv_rev;
   logic [31:0]  w3, tw;

   // SubBytes + ShiftRows, then MixColumns
   always_comb begin
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            sr[127-8*(r+4*c) -: 8] = sbox(byte_at(st_ff, r + 4*((c+r)%4)));
         end
      end
      for (int c = 0; c < 4; c++) begin
         logic [7:0] x0, x1, x2, x3, a;
         x0 = byte_at(sr, 4*c);
         x1 = byte_at(sr, 4*c+1);
         x2 = byte_at(sr, 4*c+2);
         x3 = byte_at(sr, 4*c+3);
         a  = x0 ^ x1 ^ x2 ^ x3;
         mc[127-32*c -: 32] = {x0 ^ a ^ xtime(x0 ^ x1), x1 ^ a ^ xtime(x1 ^ x2),
                               x2 ^ a ^ xtime(x2 ^ x3), x3 ^ a ^ xtime(x3 ^ x0)};
      end
      // next round key from the current one
      w3 = rk_ff[31:0];
      tw = {sbox(w3[23:16]) ^ rcon_ff, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
      nrk[127:96] = rk_ff[127:96] ^ tw;
      nrk[95:64]  = rk_ff[95:64] ^ nrk[127:96];
      nrk[63:32]  = rk_ff[63:32] ^ nrk[95:64];
      nrk[31:0]   = rk_ff[31:0] ^ nrk[63:32];
      for (int i = 0; i < BlockBytes; i++) begin
         iv_rev[127-8*i -: 8] = byte_at(iv_ff, BlockBytes - 1 - i);
      end
   end

   always_comb begin
      key_in  = key_ff;
      iv_in   = iv_ff;
      fb_in   = fb_ff;
      ks_in   = ks_ff;
      st_in   = st_ff;
      rk_in   = rk_ff;
      rcon_in = rcon_ff;
      if (cmd.start) begin
         st_in   = fb_ff ^ key_ff;
         rk_in   = key_ff;
         rcon_in = 8'h01;
      end
      if (cmd.round) begin
         st_in   = (cmd.last_round ? sr : mc) ^ nrk;
         rk_in   = nrk;
         rcon_in = xtime(rcon_ff);
      end
      if (cmd.finish) begin
         fb_in = st_in;
         ks_in = st_in ^ iv_rev;
      end
      if (csr_write) begin
         case (csr_index)
            CSR_KEY_HIGH: key_in[127:64] = csr_data;
            CSR_KEY_LOW:  key_in[63:0]   = csr_data;
            CSR_IV_HIGH:  iv_in[127:64]  = csr_data;
            CSR_IV_LOW:   iv_in[63:0]    = csr_data;
            default:      key_in = key_ff;
         endcase
      end
      if (cmd.reload_fb) begin
         fb_in = iv_in;
      end
      cipher_in = plain_ff ^ ks_ff[127-8*cmd.pos -: 8];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
         iv_ff  <= '0;
         fb_ff  <= '0;
         ks_ff  <= '0;
      end else begin
         key_ff <= key_in;
         iv_ff  <= iv_in;
         fb_ff  <= fb_in;
         ks_ff  <= ks_in;
      end
   end

   always_ff @(posedge clock) begin
      st_ff   <= st_in;
      rk_ff   <= rk_in;
      rcon_ff <= rcon_in;
      if (cmd.start || (!cmd.round && !cmd.out_load && !cmd.finish)) begin
         plain_ff <= plain_byte;
         eom_ff   <= end_of_message;
      end
      if (cmd.out_load) begin
         cipher_ff <= cipher_in;
         final_ff  <= eom_ff;
      end
   end

   assign cipher_byte = cipher_ff;
   assign final_byte  = final_ff;

endmodule
`default_nettype wire

@@ hdl/aes128_ofb_reversed_iv_mask.sv @@
// Top level of the AES-128 OFB stream block with byte-reversed IV mask.
// Instantiates aofb_ctrl and aofb_dp; uses aofb_pkg.
//
// channel  dir  beat payload
// req_     in   tdata[7:0] plain_byte, tlast end_of_message
// rsp_     out  tdata[7:0] cipher_byte, tlast final_byte
// csr_     in   index[1:0] register, data[63:0] value
//
// A byte at block position zero goes through load, ten rounds of the shared round
// unit and output; other bytes go straight from acceptance to output.
// Reset is synchronous, active high; it clears key, IV, feedback and keystream.
// A waiting result holds the output register; the next byte is taken once the
// controller is idle and that register is free or is being read in the same cycle.
`timescale 1ns / 1ps
`default_nettype none
module aes128_ofb_reversed_iv_mask
   import aofb_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [7:0]             req_tdata,  // [7:0] plain_byte
   input  wire logic                   req_tlast,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [7:0]                  rsp_tdata,  // [7:0] cipher_byte
   output logic                        rsp_tlast,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CsrIdxWidth-1:0] csr_index,
   input  wire logic [63:0]            csr_data
);

   cmd_type cmd;
   logic    csr_write, iv_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign iv_write  = csr_write && (csr_index == CSR_IV_HIGH || csr_index == CSR_IV_LOW);

   aofb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .iv_write   (iv_write),
      .cmd        (cmd)
   );

   aofb_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .cmd            (cmd),
      .plain_byte     (req_tdata),
      .end_of_message (req_tlast),
      .cipher_byte    (rsp_tdata),
      .final_byte     (rsp_tlast)
   );

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking bench for the AES-128 OFB stream block with byte-reversed IV mask.
// Drives byte beats and CSR writes and compares every ciphertext beat with an internal AES model.
// Depends on aofb_pkg and aes128_ofb_reversed_iv_mask.
`timescale 1ns / 1ps
module tb_top;
   import aofb_pkg::*;

   localparam int WatchLimit = 20000;
   localparam int SettleCycles = 40;

   localparam logic [2047:0] SBOX_TAB = {
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

   typedef struct {
      logic [7:0] data;
      logic       last;
   } byte_beat_type;

   typedef struct {
      logic [CsrIdxWidth-1:0] index;
      logic [63:0]            value;
   } csr_write_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [7:0] req_tdata = '0;
   logic req_tlast = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic rsp_tlast;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CsrIdxWidth-1:0] csr_index = '0;
   logic [63:0] csr_data = '0;

   byte_beat_type plain_q[$];
   byte_beat_type cipher_q[$];
   csr_write_type csr_q[$];
   bit hold_plain = 1'b1;
   bit no_gaps = 1'b0;
   int mismatches = 0;
   int bytes_sent = 0;
   int bytes_seen = 0;
   int csr_done = 0;
   int quiet = 0;

   // model state
   logic [127:0] mdl_key = '0, mdl_iv = '0, mdl_fb = '0, mdl_ks = '0;
   logic [3:0]   mdl_pos = '0;

   aes128_ofb_reversed_iv_mask u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [7:0] sub_byte(input logic [7:0] a);
      return SBOX_TAB[2047 - 8*a -: 8];
   endfunction

   function automatic logic [7:0] gf_dbl(input logic [7:0] b);
      return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
   endfunction

   // FIPS-197 encryption; byte 0 sits in bits 127:120
   function automatic logic [127:0] aes_encrypt(input logic [127:0] k, input logic [127:0] p);
      logic [7:0] rk [176];
      logic [7:0] s [16];
      logic [7:0] t [16];
      logic [7:0] a0, a1, a2, a3, tmp, rc, all;
      logic [127:0] res;
      for (int i = 0; i < 16; i++) begin
         rk[i] = k[127-8*i -: 8];
         s[i]  = p[127-8*i -: 8] ^ rk[i];
      end
      rc = 8'h01;
      for (int i = 4; i < 44; i++) begin
         a0 = rk[4*i-4]; a1 = rk[4*i-3]; a2 = rk[4*i-2]; a3 = rk[4*i-1];
         if (i % 4 == 0) begin
            tmp = a0;
            a0 = sub_byte(a1) ^ rc;
            a1 = sub_byte(a2);
            a2 = sub_byte(a3);
            a3 = sub_byte(tmp);
            rc = gf_dbl(rc);
         end
         rk[4*i]   = rk[4*i-16] ^ a0;
         rk[4*i+1] = rk[4*i-15] ^ a1;
         rk[4*i+2] = rk[4*i-14] ^ a2;
         rk[4*i+3] = rk[4*i-13] ^ a3;
      end
      for (int r = 1; r <= 10; r++) begin
         for (int c = 0; c < 4; c++)
            for (int i = 0; i < 4; i++)
               t[i + 4*c] = sub_byte(s[i + 4*((c + i) % 4)]);
         if (r != 10) begin
            for (int c = 0; c < 4; c++) begin
               a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
               all = a0 ^ a1 ^ a2 ^ a3;
               t[4*c]   = a0 ^ all ^ gf_dbl(a0 ^ a1);
               t[4*c+1] = a1 ^ all ^ gf_dbl(a1 ^ a2);
               t[4*c+2] = a2 ^ all ^ gf_dbl(a2 ^ a3);
               t[4*c+3] = a3 ^ all ^ gf_dbl(a3 ^ a0);
            end
         end
         for (int i = 0; i < 16; i++) s[i] = t[i] ^ rk[16*r + i];
      end
      for (int i = 0; i < 16; i++) res[127-8*i -: 8] = s[i];
      return res;
   endfunction

   function automatic logic [127:0] byte_reverse(input logic [127:0] w);
      logic [127:0] r;
      for (int i = 0; i < 16; i++) r[127-8*i -: 8] = w[8*i +: 8];
      return r;
   endfunction

   // predict the cipher beat for one plaintext beat and advance the model
   function automatic byte_beat_type encrypt_byte(input byte_beat_type b);
      byte_beat_type o;
      if (mdl_pos == 0) begin
         mdl_fb = aes_encrypt(mdl_key, mdl_fb);
         mdl_ks = mdl_fb ^ byte_reverse(mdl_iv);
      end
      o.data = b.data ^ mdl_ks[127 - 8*mdl_pos -: 8];
      o.last = b.last;
      if (b.last) begin
         mdl_fb = mdl_iv;
         mdl_pos = '0;
      end else begin
         mdl_pos = mdl_pos + 4'd1;
      end
      return o;
   endfunction

   // driver
   always @(posedge clock) begin
      byte_beat_type b;
      csr_write_type w;
      if (!reset) begin
         if (!req_tvalid || req_tready) begin
            if (plain_q.size() > 0 && !hold_plain && (no_gaps || $urandom_range(99) >= 38)) begin
               b = plain_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= b.data;
               req_tlast <= b.last;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         if (!csr_valid || csr_ready) begin
            if (csr_q.size() > 0) begin
               w = csr_q.pop_front();
               csr_valid <= 1'b1;
               csr_index <= w.index;
               csr_data <= w.value;
            end else begin
               csr_valid <= 1'b0;
            end
         end
         rsp_tready <= no_gaps ? 1'b1 : ($urandom_range(99) >= 38);
      end
   end

   // monitor, model and watchdog
   always @(posedge clock) begin
      byte_beat_type exp_b;
      bit moved;
      moved = 1'b0;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            moved = 1'b1;
            case (csr_index)
               CSR_KEY_HIGH: mdl_key[127:64] = csr_data;
               CSR_KEY_LOW:  mdl_key[63:0] = csr_data;
               CSR_IV_HIGH, CSR_IV_LOW: begin
                  if (csr_index == CSR_IV_HIGH) mdl_iv[127:64] = csr_data;
                  else mdl_iv[63:0] = csr_data;
                  mdl_fb = mdl_iv;
                  mdl_pos = '0;
               end
               default: ;
            endcase
            csr_done++;
         end
         if (req_tvalid && req_tready) begin
            moved = 1'b1;
            exp_b.data = req_tdata;
            exp_b.last = req_tlast;
            cipher_q.insert(cipher_q.size(), encrypt_byte(exp_b));
            bytes_sent++;
         end
         if (rsp_tvalid && rsp_tready) begin
            moved = 1'b1;
            bytes_seen++;
            if (cipher_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected cipher beat data=%h last=%b", rsp_tdata, rsp_tlast);
            end else begin
               exp_b = cipher_q.pop_front();
               if (rsp_tdata !== exp_b.data || rsp_tlast !== exp_b.last) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("beat %0d: expected data=%h last=%b, got data=%h last=%b",
                              bytes_seen, exp_b.data, exp_b.last, rsp_tdata, rsp_tlast);
               end
            end
         end
         quiet = moved ? 0 : quiet + 1;
         if (quiet >= WatchLimit) begin
            $display("watchdog: no beat for %0d cycles", WatchLimit);
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   task automatic push_csr(input logic [CsrIdxWidth-1:0] idx, input logic [63:0] val);
      csr_write_type w;
      w.index = idx;
      w.value = val;
      csr_q.insert(csr_q.size(), w);
   endtask

   task automatic push_byte(input logic [7:0] d, input logic l);
      byte_beat_type b;
      b.data = d;
      b.last = l;
      plain_q.insert(plain_q.size(), b);
   endtask

   // stop feeding bytes and wait until every sent byte has come back;
   // checked at the falling edge so driver and monitor updates have settled
   task automatic wait_drained();
      wait (plain_q.size() == 0);
      hold_plain = 1'b1;
      do @(negedge clock);
      while (req_tvalid || cipher_q.size() != 0);
   endtask

   // let queued plaintext drain, then apply CSR writes while idle
   task automatic reconfigure();
      int target;
      wait_drained();
      repeat (SettleCycles) @(posedge clock);
      target = csr_done + csr_q.size();
      wait (csr_done == target);
      @(posedge clock);
      hold_plain = 1'b0;
   endtask

   function automatic logic [63:0] rand64(input int phase);
      if (phase == 0) return '0;
      if (phase == 1) return '1;
      return {$urandom(), $urandom()};
   endfunction

   initial begin
      int len;
      logic [3:0] mask;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: standard test key, wrap past one block, then mid-block CSR writes
      push_csr(CSR_KEY_HIGH, 64'h0001020304050607);
      push_csr(CSR_KEY_LOW,  64'h08090a0b0c0d0e0f);
      push_csr(CSR_IV_HIGH,  64'h00112233_44556677);
      push_csr(CSR_IV_LOW,   64'h8899aabb_ccddeeff);
      reconfigure();
      push_byte(8'h00, 1'b0);
      push_byte(8'hff, 1'b0);
      for (int i = 0; i < 18; i++) push_byte(8'h55 ^ 8'(i), 1'b0);
      reconfigure();
      // key changes mid-block: rest of the block keeps the old keystream
      push_csr(CSR_KEY_LOW, 64'hffffffffffffffff);
      reconfigure();
      for (int i = 0; i < 13; i++) push_byte(8'(i * 37), 1'b0);
      push_byte(8'haa, 1'b1);
      push_byte(8'h0f, 1'b1);
      push_byte(8'h3c, 1'b0);
      reconfigure();
      // IV write mid-message restarts the message
      push_csr(CSR_IV_LOW, 64'h0);
      reconfigure();
      push_byte(8'hff, 1'b0);
      push_byte(8'h81, 1'b1);

      // random phases: mostly whole messages, a few without end mark
      for (int ph = 0; ph < 8; ph++) begin
         reconfigure();
         mask = (ph < 2) ? 4'hf : 4'($urandom_range(1, 15));
         for (int r = 0; r < 4; r++)
            if (mask[r]) push_csr(r[CsrIdxWidth-1:0], rand64(ph));
         reconfigure();
         no_gaps = (ph == 4);
         for (int n = 0; n < 200; ) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(33, 50) : $urandom_range(1, 20);
            for (int i = 0; i < len; i++)
               push_byte(8'($urandom()), (i == len - 1) ? ($urandom_range(7) != 0) : 1'b0);
            n += len;
         end
      end
      wait_drained();
      no_gaps = 1'b0;
      repeat (SettleCycles) @(posedge clock);
      $display("%0d plaintext beats over 8 random key/IV settings plus directed wrap,",
               bytes_sent);
      $display("mid-block key and IV writes; %0d cipher beats checked", bytes_seen);
      if (mismatches == 0 && cipher_q.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
